/* rtl/uct_emf_pkg.sv */
// ----------------------------------------------------------------------------
// Corner EMF package
// Shared widths, the controller state type and the datapath command struct.
// ----------------------------------------------------------------------------
package uct_emf_pkg;

   localparam int DataWidth = 32;
   localparam int FracBits  = 16;

   typedef logic signed [DataWidth-1:0] data_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic step1;
      logic step2;
   } cmd_type;

   function automatic data_type sat_wide(input logic signed [DataWidth+1:0] v);
      logic signed [DataWidth+1:0] hi;
      logic signed [DataWidth+1:0] lo;
      hi = (DataWidth+2)'({1'b0, {(DataWidth-1){1'b1}}});
      lo = -hi - (DataWidth+2)'(1);
      if (v > hi) return data_type'(hi);
      if (v < lo) return data_type'(lo);
      return data_type'(v);
   endfunction

endpackage

/* rtl/uct_emf_ctrl.sv */
// ----------------------------------------------------------------------------
// Corner EMF controller
// Sequences one beat through load, two product steps and result hand-off.
// ----------------------------------------------------------------------------
module uct_emf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output uct_emf_pkg::cmd_type cmd
);
   import uct_emf_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_MUL1;
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_OUT;
         ST_OUT:  if (!rsp_stall) state_in = req_valid ? ST_MUL1 : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // A new beat may be taken in the cycle the held result leaves.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_MUL1: cmd.step1 = 1'b1;
         ST_MUL2: cmd.step2 = 1'b1;
         ST_OUT: begin
            rsp_valid = 1'b1;
            req_stall = rsp_stall;
            cmd.load  = req_valid && !rsp_stall;
         end
         default: ;
      endcase
   end
endmodule

/* rtl/uct_emf_dp.sv */
// ----------------------------------------------------------------------------
// Corner EMF datapath
// Windows, MC reconstruction, shared multipliers and saturating sums.
// ----------------------------------------------------------------------------
module uct_emf_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  uct_emf_pkg::cmd_type  cmd,
   input  logic                  phi_sign,
   input  uct_emf_pkg::data_type field_next,
   input  uct_emf_pkg::data_type face_emf_next,
   input  uct_emf_pkg::data_type speed_left_a,
   input  uct_emf_pkg::data_type speed_left_b,
   input  uct_emf_pkg::data_type speed_right_a,
   input  uct_emf_pkg::data_type speed_right_b,
   input  uct_emf_pkg::data_type diff_left_a,
   input  uct_emf_pkg::data_type diff_left_b,
   input  uct_emf_pkg::data_type diff_right_a,
   input  uct_emf_pkg::data_type diff_right_b,
   output uct_emf_pkg::data_type corner_emf
);
   import uct_emf_pkg::*;

   localparam int W  = DataWidth;
   localparam int WX = DataWidth + 2;

   typedef logic signed [WX-1:0] wide_type;

   data_type fw_ff [3];
   data_type ew_ff [3];
   data_type bl_ff, br_ff, vl_ff, vr_ff;
   data_type al_ff, ar_ff, dl_ff, dr_ff;
   data_type pl_ff, pr_ff, ql_ff, qr_ff;
   data_type res_ff;

   function automatic wide_type half_slope(input data_type nxt, input data_type ctr,
                                           input data_type prv);
      wide_type dp, dm, mn, c, amn, ac, adp, adm;
      dp  = wide_type'(nxt) - wide_type'(ctr);
      dm  = wide_type'(ctr) - wide_type'(prv);
      adp = dp < 0 ? -dp : dp;
      adm = dm < 0 ? -dm : dm;
      mn  = adp < adm ? dp : dm;
      amn = mn < 0 ? -mn : mn;
      c   = dp + dm;
      ac  = c < 0 ? -c : c;
      if ((dp < 0 && dm > 0) || (dp > 0 && dm < 0)) return '0;
      if ({2'b0, ac} < {amn, 2'b0}) return c >>> 2;
      return mn;
   endfunction

   function automatic data_type avg(input data_type a, input data_type b);
      logic signed [W:0] s;
      s = {a[W-1], a} + {b[W-1], b};
      return data_type'(s >>> 1);
   endfunction

   function automatic data_type prod(input data_type x, input data_type y);
      logic signed [2*W-1:0] p;
      logic signed [2*W-1:0] sh;
      p  = x * y;
      sh = p >>> FracBits;
      if (sh > (2*W)'(wide_type'({1'b0, {(W-1){1'b1}}})))
         return {1'b0, {(W-1){1'b1}}};
      if (sh < -(2*W)'(wide_type'({1'b0, {(W-1){1'b1}}})) - (2*W)'(1))
         return {1'b1, {(W-1){1'b0}}};
      return data_type'(sh);
   endfunction

   // The shared pair of multipliers takes the first products, then the second.
   data_type m0_a, m0_b, m1_a, m1_b, m0_p, m1_p;
   always_comb begin
      if (cmd.step1) begin
         m0_a = al_ff; m0_b = vl_ff; m1_a = ar_ff; m1_b = vr_ff;
      end else begin
         m0_a = pl_ff; m0_b = bl_ff; m1_a = pr_ff; m1_b = br_ff;
      end
   end
   assign m0_p = prod(m0_a, m0_b);
   assign m1_p = prod(m1_a, m1_b);

   data_type ql_m, qr_m, sum_w, phi_w;
   assign ql_m  = prod(dl_ff, bl_ff);
   assign qr_m  = prod(dr_ff, br_ff);
   assign sum_w = sat_wide(wide_type'(m0_p) + wide_type'(m1_p));
   assign phi_w = sat_wide(wide_type'(qr_ff) - wide_type'(ql_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            fw_ff[k] <= '0;
            ew_ff[k] <= '0;
         end
      end else if (cmd.load) begin
         fw_ff[0] <= fw_ff[1]; fw_ff[1] <= fw_ff[2]; fw_ff[2] <= field_next;
         ew_ff[0] <= ew_ff[1]; ew_ff[1] <= ew_ff[2]; ew_ff[2] <= face_emf_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         bl_ff <= sat_wide(wide_type'(fw_ff[1]) + half_slope(fw_ff[2], fw_ff[1], fw_ff[0]));
         br_ff <= sat_wide(wide_type'(fw_ff[2]) - half_slope(field_next, fw_ff[2], fw_ff[1]));
         vl_ff <= sat_wide(wide_type'(ew_ff[1]) + half_slope(ew_ff[2], ew_ff[1], ew_ff[0]));
         vr_ff <= sat_wide(wide_type'(ew_ff[2]) - half_slope(face_emf_next, ew_ff[2], ew_ff[1]));
         al_ff <= avg(speed_left_a, speed_left_b);
         ar_ff <= avg(speed_right_a, speed_right_b);
         dl_ff <= avg(diff_left_a, diff_left_b);
         dr_ff <= avg(diff_right_a, diff_right_b);
      end
      if (cmd.step1) begin
         pl_ff <= m0_p;
         pr_ff <= m1_p;
         ql_ff <= ql_m;
         qr_ff <= qr_m;
      end
      if (cmd.step2) begin
         res_ff <= phi_sign ? sat_wide(wide_type'(sum_w) - wide_type'(phi_w))
                            : sat_wide(wide_type'(sum_w) + wide_type'(phi_w));
      end
   end

   assign corner_emf = res_ff;
endmodule

/* rtl/uct_corner_emf_mc_limited_unit.sv */
// ----------------------------------------------------------------------------
// Corner EMF unit with MC-limited reconstruction
// Streams one grid line and returns one directional corner EMF per beat.
// ----------------------------------------------------------------------------
// Usage: each req_ beat carries the next field and face EMF samples and the
// transverse wave and diffusion coefficients. Every request beat yields
// exactly one rsp_ beat with the saturated Q16.16 corner EMF.
// Sequence: a beat accepted in idle is loaded into the windows, passes the
// first and second multiplier steps, and is written into the result
// register, which then raises rsp_valid. The pair of multipliers is shared
// by the two product steps, and the result register holds one beat, so a
// new beat is not taken before the held result is taken.
// The next request is taken in the same cycle the held result is taken.
// Reset clears the sample windows, the controller and the stored sign. The
// first three results of a line use zeroed window entries and are meant to
// be discarded by the consumer.
// When rsp_stall is high while rsp_valid is high, the result stays stable and req_stall stays high.
// csr_phi_sign selects subtraction of the diffusive term when set; write it
// only while the unit is idle.
// ----------------------------------------------------------------------------
module uct_corner_emf_mc_limited_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic                  csr_phi_sign,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  uct_emf_pkg::data_type req_field_next,
   input  uct_emf_pkg::data_type req_face_emf_next,
   input  uct_emf_pkg::data_type req_speed_left_a,
   input  uct_emf_pkg::data_type req_speed_left_b,
   input  uct_emf_pkg::data_type req_speed_right_a,
   input  uct_emf_pkg::data_type req_speed_right_b,
   input  uct_emf_pkg::data_type req_diff_left_a,
   input  uct_emf_pkg::data_type req_diff_left_b,
   input  uct_emf_pkg::data_type req_diff_right_a,
   input  uct_emf_pkg::data_type req_diff_right_b,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output uct_emf_pkg::data_type rsp_corner_emf
);
   import uct_emf_pkg::*;

   logic    phi_sign_ff;
   cmd_type cmd;

   // Sign of the diffusive term, held from the last write.
   always_ff @(posedge clock) begin
      if (reset)          phi_sign_ff <= 1'b0;
      else if (csr_write) phi_sign_ff <= csr_phi_sign;
   end

   uct_emf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   uct_emf_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .phi_sign      (phi_sign_ff),
      .field_next    (req_field_next),
      .face_emf_next (req_face_emf_next),
      .speed_left_a  (req_speed_left_a),
      .speed_left_b  (req_speed_left_b),
      .speed_right_a (req_speed_right_a),
      .speed_right_b (req_speed_right_b),
      .diff_left_a   (req_diff_left_a),
      .diff_left_b   (req_diff_left_b),
      .diff_right_a  (req_diff_right_a),
      .diff_right_b  (req_diff_right_b),
      .corner_emf    (rsp_corner_emf)
   );
endmodule
